### rtl/gsas_pkg.sv
// Shared types and constants for the gas sensor acquisition sequencer.
// Used by every module under rtl/; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package gsas_pkg;

	// Field widths
	localparam int ADC_BITS = 12;
	localparam int TICK_W   = 20;
	localparam int GAIN_W   = 16;
	localparam int PPM_W    = 16;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 4;

	// Limits
	localparam logic [TICK_W-1:0] TICK_MAX   = {TICK_W{1'b1}};
	localparam logic [PPM_W-1:0]  PPM_MAX_Q8 = 16'd51200;

	// Register reset values
	localparam logic [TICK_W-1:0]   WARMUP_RST     = 20'd5000;
	localparam logic [TICK_W-1:0]   INTERVAL_RST   = 20'd2000;
	localparam logic [ADC_BITS-1:0] DISCONNECT_RST = 12'd125;
	localparam logic [GAIN_W-1:0]   GAIN_RST       = 16'd26449;

	// Register indexes (byte address / 4)
	typedef enum logic [1:0] {
		REG_WARMUP     = 2'd0,
		REG_INTERVAL   = 2'd1,
		REG_DISCONNECT = 2'd2,
		REG_GAIN       = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_WARMUP  = 2'd0,
		PH_READY   = 2'd1,
		PH_COLLECT = 2'd2
	} phase_t;

	typedef struct packed {
		logic                button_level;
		logic [ADC_BITS-1:0] gas_sample;
		logic [ADC_BITS-1:0] hcho_sample;
		logic [ADC_BITS-1:0] voc_sample;
		logic [ADC_BITS-1:0] nh3_sample;
	} sample_t;

	typedef struct packed {
		logic [PPM_W-1:0]    alcohol_ppm_q8;
		logic                gas_connected;
		logic [ADC_BITS-1:0] hcho_raw;
		logic                hcho_connected;
		logic [ADC_BITS-1:0] voc_raw;
		logic                voc_connected;
		logic [ADC_BITS-1:0] nh3_raw;
		logic                nh3_connected;
	} reading_t;

	typedef struct packed {
		logic [TICK_W-1:0]   warmup_ticks;
		logic [TICK_W-1:0]   read_interval_ticks;
		logic [ADC_BITS-1:0] disconnect_raw;
		logic [GAIN_W-1:0]   ppm_gain;
	} cfg_t;

	typedef struct packed {
		phase_t              phase;
		logic                emit;
		logic [ADC_BITS-1:0] baseline;
	} ctrl_t;

endpackage

`default_nettype wire

### rtl/gas_sensor_acquisition_sequencer_unit.sv
// Usage: each beat on the sample channel is one time tick carrying the
// button level and four ADC samples; beats on the reading channel carry
// one alcohol ppm value (Q8.8) plus the other raw samples and flags.
// Both channels use valid/ready; configuration goes over the APB port
// (warm-up ticks 0x0, read interval 0x4, disconnect threshold 0x8,
// gain 0xC), for the user to write only while the block is idle; the
// block does not enforce this. A sample beat is taken into the input
// register, and a reading it causes is loaded from there into the
// output register. Throughput: one tick per cycle, set by the single
// input register feeding the sequencer and the 12x16 gain multiplier.
// A tick that yields no reading moves on even while the output is full;
// a tick that yields one waits in the input register while the receiver
// stalls, and the sample channel then stops taking beats.
// Reset: the block enters warm-up with a zero tick count, the button seen
// as released, a zero baseline and registers at their defaults.
// Depends on gsas_pkg, gsas_regs, gsas_ctrl and gsas_calc.
`timescale 1ns / 1ps
`default_nettype none

module gas_sensor_acquisition_sequencer_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [gsas_pkg::ADDR_W-1:0] paddr,
	input  wire logic [gsas_pkg::DATA_W-1:0] pwdata,
	output logic      [gsas_pkg::DATA_W-1:0] prdata,
	output logic                             pready,
	input  wire logic                        sample_valid,
	output logic                             sample_ready,
	input  wire gsas_pkg::sample_t           sample,
	output logic                             reading_valid,
	input  wire logic                        reading_ready,
	output gsas_pkg::reading_t               reading
);
	import gsas_pkg::*;

	cfg_t     cfg;
	ctrl_t    ctl;
	sample_t  sample_s1;
	logic     valid_s1;
	reading_t calc_out;
	reading_t reading_q;
	logic     reading_valid_q;
	logic     out_free, s1_go;

	gsas_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gsas_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (s1_go),
		.item   (sample_s1),
		.cfg    (cfg),
		.ctl    (ctl)
	);

	gsas_calc u_calc (
		.item     (sample_s1),
		.baseline (ctl.baseline),
		.cfg      (cfg),
		.reading  (calc_out)
	);

	// Handshake: hold a result-bearing tick while a full output is stalled
	assign out_free     = !reading_valid_q || reading_ready;
	assign s1_go        = valid_s1 && (!ctl.emit || out_free);
	assign sample_ready = !valid_s1 || s1_go;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) sample_s1 <= sample;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reading_valid_q <= 1'b0;
		end else if (s1_go && ctl.emit) begin
			reading_valid_q <= 1'b1;
		end else if (reading_ready) begin
			reading_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && ctl.emit) reading_q <= calc_out;
	end

	assign reading_valid = reading_valid_q;
	assign reading       = reading_q;

`ifndef SYNTHESIS
	a_emit_only_collecting : assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> ctl.phase == PH_COLLECT)
		else $error("reading raised outside collecting phase");

	a_no_return_to_warmup : assert property (@(posedge clk) disable iff (!arst_n)
		ctl.phase != PH_WARMUP |=> ctl.phase != PH_WARMUP)
		else $error("sequencer fell back into warm-up");

	a_ppm_clamped : assert property (@(posedge clk) disable iff (!arst_n)
		reading_valid |-> reading.alcohol_ppm_q8 <= PPM_MAX_Q8)
		else $error("alcohol ppm above clamp");

	a_emit_loads_output : assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && ctl.emit |=> reading_valid)
		else $error("emitted tick did not load the output register");
`endif

endmodule

`default_nettype wire

### rtl/gsas_regs.sv
// APB-style configuration registers of the gas sensor sequencer.
// Depends on gsas_pkg for the register map and the cfg_t bundle.
`timescale 1ns / 1ps
`default_nettype none

module gsas_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [gsas_pkg::ADDR_W-1:0] paddr,
	input  wire logic [gsas_pkg::DATA_W-1:0] pwdata,
	output logic      [gsas_pkg::DATA_W-1:0] prdata,
	output logic                             pready,
	output gsas_pkg::cfg_t                   cfg
);
	import gsas_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	// Write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.warmup_ticks        <= WARMUP_RST;
			cfg_q.read_interval_ticks <= INTERVAL_RST;
			cfg_q.disconnect_raw      <= DISCONNECT_RST;
			cfg_q.ppm_gain            <= GAIN_RST;
		end else if (wr_en) begin
			case (idx)
				REG_WARMUP:     cfg_q.warmup_ticks        <= pwdata[TICK_W-1:0];
				REG_INTERVAL:   cfg_q.read_interval_ticks <= pwdata[TICK_W-1:0];
				REG_DISCONNECT: cfg_q.disconnect_raw      <= pwdata[ADC_BITS-1:0];
				REG_GAIN:       cfg_q.ppm_gain            <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back, zero extended
	always_comb begin
		case (idx)
			REG_WARMUP:     prdata = {{(DATA_W-TICK_W){1'b0}}, cfg_q.warmup_ticks};
			REG_INTERVAL:   prdata = {{(DATA_W-TICK_W){1'b0}}, cfg_q.read_interval_ticks};
			REG_DISCONNECT: prdata = {{(DATA_W-ADC_BITS){1'b0}}, cfg_q.disconnect_raw};
			REG_GAIN:       prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_q.ppm_gain};
			default:        prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

### rtl/gsas_ctrl.sv
// Phase sequencer: warm-up, ready and collecting, tick counter, button edge
// and baseline capture. Depends on gsas_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gsas_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire gsas_pkg::sample_t item,
	input  wire gsas_pkg::cfg_t    cfg,
	output gsas_pkg::ctrl_t       ctl
);
	import gsas_pkg::*;

	phase_t              phase_q, phase_d;
	logic [TICK_W-1:0]   ticks_q, ticks_d, ticks_bump;
	logic                btn_prev_q;
	logic [ADC_BITS-1:0] baseline_q;
	logic                pressed, base_load, emit, gas_ok;

	assign pressed    = btn_prev_q & ~item.button_level;
	assign gas_ok     = item.gas_sample >= cfg.disconnect_raw;
	assign ticks_bump = (ticks_q == TICK_MAX) ? ticks_q : ticks_q + 1'b1;

	// Next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_WARMUP: begin
				if (ticks_bump >= cfg.warmup_ticks) phase_d = PH_READY;
			end
			PH_READY: begin
				if (pressed) phase_d = PH_COLLECT;
			end
			PH_COLLECT: begin
				if (pressed) phase_d = PH_READY;
			end
			default: phase_d = PH_WARMUP;
		endcase
	end

	// Counter, baseline load and emit
	always_comb begin
		ticks_d   = ticks_q;
		base_load = 1'b0;
		emit      = 1'b0;
		case (phase_q)
			PH_WARMUP: begin
				ticks_d   = ticks_bump;
				base_load = (ticks_bump >= cfg.warmup_ticks) && gas_ok;
			end
			PH_READY: begin
				if (pressed) ticks_d = '0;
			end
			PH_COLLECT: begin
				if (!pressed) begin
					if (ticks_bump >= cfg.read_interval_ticks) begin
						emit    = 1'b1;
						ticks_d = '0;
					end else begin
						ticks_d = ticks_bump;
					end
				end
			end
			default: ;
		endcase
	end

	// Advance state once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_WARMUP;
			ticks_q    <= '0;
			btn_prev_q <= 1'b1;
			baseline_q <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			ticks_q    <= ticks_d;
			btn_prev_q <= item.button_level;
			if (base_load) baseline_q <= item.gas_sample;
		end
	end

	assign ctl.phase    = phase_q;
	assign ctl.emit     = emit;
	assign ctl.baseline = baseline_q;

endmodule

`default_nettype wire

### rtl/gsas_calc.sv
// Reading datapath: alcohol ppm in Q8.8 from baseline and gain, connected
// flags and raw pass-through. Depends on gsas_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gsas_calc (
	input  wire gsas_pkg::sample_t           item,
	input  wire logic [gsas_pkg::ADC_BITS-1:0] baseline,
	input  wire gsas_pkg::cfg_t              cfg,
	output gsas_pkg::reading_t               reading
);
	import gsas_pkg::*;

	localparam int PROD_W = ADC_BITS + GAIN_W;

	logic [ADC_BITS-1:0] diff;
	logic [PROD_W-1:0]   prod;
	logic [PROD_W:0]     rounded;
	logic [PROD_W-4:0]   q8;
	logic [PPM_W-1:0]    ppm;
	logic                gas_ok, above;

	assign gas_ok  = item.gas_sample >= cfg.disconnect_raw;
	assign above   = item.gas_sample > baseline;
	assign diff    = item.gas_sample - baseline;
	// Q.12 product, round half up to Q8.8
	assign prod    = PROD_W'(diff) * PROD_W'(cfg.ppm_gain);
	assign rounded = {1'b0, prod} + (PROD_W+1)'(8);
	assign q8      = rounded[PROD_W:4];
	// Clamp to 200 ppm
	assign ppm     = (q8 > (PROD_W-3)'(PPM_MAX_Q8)) ? PPM_MAX_Q8 : q8[PPM_W-1:0];

	always_comb begin
		reading.alcohol_ppm_q8 = (gas_ok && above) ? ppm : '0;
		reading.gas_connected  = gas_ok;
		reading.hcho_raw       = item.hcho_sample;
		reading.hcho_connected = item.hcho_sample >= cfg.disconnect_raw;
		reading.voc_raw        = item.voc_sample;
		reading.voc_connected  = item.voc_sample >= cfg.disconnect_raw;
		reading.nh3_raw        = item.nh3_sample;
		reading.nh3_connected  = item.nh3_sample >= cfg.disconnect_raw;
	end

endmodule

`default_nettype wire

### tb/gas_sensor_acquisition_sequencer_unit_test.sv
// Self-checking testbench for gas_sensor_acquisition_sequencer_unit.
// Drives sample ticks and APB register writes, predicts each reading and
// checks it. Depends on gsas_pkg and the unit under rtl/.
`timescale 1ns / 1ps

module gas_sensor_acquisition_sequencer_unit_test;
	import gsas_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 4;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                sample_valid;
	logic                sample_ready;
	sample_t             tick_in;
	logic                reading_valid;
	logic                reading_ready;
	reading_t            reading_out;

	// Predictor copy of the sequencer state and registers
	cfg_t                regs_model;
	phase_t              seq_phase;
	logic [TICK_W-1:0]   tick_count;
	logic                btn_last;
	logic [ADC_BITS-1:0] base_raw;

	reading_t            pending_readings[$];
	int                  mismatches;
	int                  ticks_sent;
	int                  readings_checked;
	int                  cycle_count;
	int                  gap_pct;
	int                  stall_pct;
	logic                btn_level_now;

	gas_sensor_acquisition_sequencer_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.sample_valid  (sample_valid),
		.sample_ready  (sample_ready),
		.sample        (tick_in),
		.reading_valid (reading_valid),
		.reading_ready (reading_ready),
		.reading       (reading_out)
	);

	always #4 clk = ~clk;

	// Advance the sequencer by one tick; return 1 when a reading comes out
	function automatic bit tick_predict(input sample_t s, output reading_t r);
		bit          press;
		bit          gas_ok;
		logic [31:0] diff;
		logic [31:0] q8;
		press = btn_last && !s.button_level;
		btn_last = s.button_level;
		r = '0;
		case (seq_phase)
			PH_WARMUP: begin
				tick_count = (tick_count == TICK_MAX) ? tick_count : tick_count + 1'b1;
				if (tick_count >= regs_model.warmup_ticks) begin
					if (s.gas_sample >= regs_model.disconnect_raw)
						base_raw = s.gas_sample;
					seq_phase = PH_READY;
				end
				return 0;
			end
			PH_COLLECT: begin
				if (press) begin
					seq_phase = PH_READY;
					return 0;
				end
				tick_count = (tick_count == TICK_MAX) ? tick_count : tick_count + 1'b1;
				if (tick_count < regs_model.read_interval_ticks)
					return 0;
				tick_count = '0;
				gas_ok = s.gas_sample >= regs_model.disconnect_raw;
				q8 = '0;
				if (gas_ok && s.gas_sample > base_raw) begin
					diff = 32'(s.gas_sample) - 32'(base_raw);
					q8 = (diff * 32'(regs_model.ppm_gain) + 32'd8) >> 4;
					if (q8 > 32'(PPM_MAX_Q8))
						q8 = 32'(PPM_MAX_Q8);
				end
				r.alcohol_ppm_q8 = q8[PPM_W-1:0];
				r.gas_connected  = gas_ok;
				r.hcho_raw       = s.hcho_sample;
				r.hcho_connected = s.hcho_sample >= regs_model.disconnect_raw;
				r.voc_raw        = s.voc_sample;
				r.voc_connected  = s.voc_sample >= regs_model.disconnect_raw;
				r.nh3_raw        = s.nh3_sample;
				r.nh3_connected  = s.nh3_sample >= regs_model.disconnect_raw;
				return 1;
			end
			default: begin
				if (press) begin
					seq_phase = PH_COLLECT;
					tick_count = '0;
				end
				return 0;
			end
		endcase
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	function automatic logic [ADC_BITS-1:0] pick_near(int center, int span);
		int v;
		v = center - span + int'($urandom_range(0, 2 * span));
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return v[ADC_BITS-1:0];
	endfunction

	// Check each reading beat, then predict each accepted sample beat
	always @(posedge clk) begin : monitor
		reading_t want;
		reading_t predicted;
		if (reading_valid && reading_ready) begin
			if (pending_readings.size() == 0) begin
				$error("reading beat with no reading expected");
				mismatches++;
			end else begin
				want = pending_readings.pop_front();
				check_field("alcohol_ppm_q8", want.alcohol_ppm_q8, reading_out.alcohol_ppm_q8);
				check_field("gas_connected", want.gas_connected, reading_out.gas_connected);
				check_field("hcho_raw", want.hcho_raw, reading_out.hcho_raw);
				check_field("hcho_connected", want.hcho_connected, reading_out.hcho_connected);
				check_field("voc_raw", want.voc_raw, reading_out.voc_raw);
				check_field("voc_connected", want.voc_connected, reading_out.voc_connected);
				check_field("nh3_raw", want.nh3_raw, reading_out.nh3_raw);
				check_field("nh3_connected", want.nh3_connected, reading_out.nh3_connected);
				readings_checked++;
			end
		end
		if (sample_valid && sample_ready) begin
			ticks_sent++;
			if (tick_predict(tick_in, predicted))
				pending_readings.push_back(predicted);
		end
	end

	// Stall the reading channel at random
	always @(negedge clk) begin
		reading_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Send one tick beat; starts and ends at a falling edge
	task automatic send_tick(input logic btn, input logic [ADC_BITS-1:0] gas,
			input logic [ADC_BITS-1:0] hcho, input logic [ADC_BITS-1:0] voc,
			input logic [ADC_BITS-1:0] nh3);
		sample_t s;
		s.button_level = btn;
		s.gas_sample   = gas;
		s.hcho_sample  = hcho;
		s.voc_sample   = voc;
		s.nh3_sample   = nh3;
		while ($urandom_range(0, 99) < gap_pct) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		tick_in <= s;
		do begin
			@(posedge clk);
		end while (!sample_ready);
		@(negedge clk);
		btn_level_now = btn;
	endtask

	// Drop valid, wait out every reading and the pipeline behind it
	task automatic drain;
		sample_valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_WARMUP:     regs_model.warmup_ticks        = value[TICK_W-1:0];
			REG_INTERVAL:   regs_model.read_interval_ticks = value[TICK_W-1:0];
			REG_DISCONNECT: regs_model.disconnect_raw      = value[ADC_BITS-1:0];
			default:        regs_model.ppm_gain            = value[GAIN_W-1:0];
		endcase
	endtask

	// Warm-up consumes presses, ignores a disconnected sample, and captures
	// the baseline on the tick where the count reaches the warm-up setting
	task automatic test_warmup_and_baseline;
		reg_write(REG_WARMUP, 32'hFFFFF);
		reg_write(REG_INTERVAL, 32'd1);
		reg_write(REG_DISCONNECT, 32'd125);
		reg_write(REG_GAIN, 32'd26449);
		send_tick(1'b0, 12'd3000, 12'd10, 12'd20, 12'd30);
		send_tick(1'b1, 12'd3000, 12'd10, 12'd20, 12'd30);
		send_tick(1'b1, 12'd50, 12'd10, 12'd20, 12'd30);
		drain();
		// a zero warm-up ends it on the very next tick
		reg_write(REG_WARMUP, 32'd0);
		send_tick(1'b1, 12'd1000, 12'd10, 12'd20, 12'd30);
		drain();
	endtask

	// Start collecting and walk the alcohol value through its corner cases
	task automatic test_reading_values;
		send_tick(1'b0, 12'd0, 12'd0, 12'd0, 12'd0);
		send_tick(1'b1, 12'd4095, 12'd0, 12'd4095, 12'd124);
		send_tick(1'b1, 12'd1000, 12'd125, 12'd124, 12'd4095);
		send_tick(1'b1, 12'd999, 12'd2730, 12'd1365, 12'd125);
		send_tick(1'b1, 12'd1001, 12'd1365, 12'd2730, 12'd0);
		send_tick(1'b1, 12'd124, 12'd4095, 12'd125, 12'd126);
		send_tick(1'b1, 12'd125, 12'd126, 12'd0, 12'd2048);
		send_tick(1'b1, 12'd1031, 12'd2048, 12'd2047, 12'd2047);
		send_tick(1'b1, 12'd1030, 12'd2047, 12'd2048, 12'd1000);
		// stop, hold pressed, release, start again
		send_tick(1'b0, 12'd2000, 12'd500, 12'd500, 12'd500);
		send_tick(1'b0, 12'd2000, 12'd500, 12'd500, 12'd500);
		send_tick(1'b1, 12'd2000, 12'd500, 12'd500, 12'd500);
		send_tick(1'b0, 12'd2000, 12'd500, 12'd500, 12'd500);
		drain();
	endtask

	// Drive disconnect, gain and interval to their limits while collecting
	task automatic test_register_extremes;
		reg_write(REG_DISCONNECT, 32'd0);
		reg_write(REG_GAIN, 32'd65535);
		send_tick(1'b1, 12'd0, 12'd0, 12'd0, 12'd0);
		send_tick(1'b1, 12'd1001, 12'd1, 12'd2, 12'd3);
		drain();
		reg_write(REG_DISCONNECT, 32'd4095);
		send_tick(1'b1, 12'd4095, 12'd4095, 12'd4094, 12'd4095);
		send_tick(1'b1, 12'd4094, 12'd4094, 12'd4095, 12'd4094);
		drain();
		reg_write(REG_GAIN, 32'd0);
		send_tick(1'b1, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
		drain();
		// a zero interval emits on every tick
		reg_write(REG_INTERVAL, 32'd0);
		send_tick(1'b1, 12'd3000, 12'd200, 12'd300, 12'd400);
		send_tick(1'b1, 12'd3001, 12'd201, 12'd301, 12'd401);
		drain();
		reg_write(REG_INTERVAL, 32'hFFFFF);
		reg_write(REG_WARMUP, 32'd5000);
		send_tick(1'b1, 12'd3000, 12'd200, 12'd300, 12'd400);
		send_tick(1'b1, 12'd3000, 12'd200, 12'd300, 12'd400);
		send_tick(1'b0, 12'd3000, 12'd200, 12'd300, 12'd400);
		drain();
	endtask

	// Random register settings, then ticks with sparse button presses
	task automatic test_random_traffic(input int gap, input int stall, input int count);
		logic                btn;
		logic [ADC_BITS-1:0] gas;
		logic [ADC_BITS-1:0] oth[3];
		gap_pct   = gap;
		stall_pct = stall;
		reg_write(REG_WARMUP, 32'($urandom_range(0, 1048575)));
		reg_write(REG_INTERVAL, 32'($urandom_range(1, 6)));
		reg_write(REG_DISCONNECT, ($urandom_range(0, 3) != 0) ?
			32'($urandom_range(0, 400)) : 32'($urandom_range(0, 4095)));
		reg_write(REG_GAIN, ($urandom_range(0, 1) != 0) ?
			32'($urandom_range(0, 65535)) : 32'($urandom_range(0, 3000)));
		for (int i = 0; i < count; i++) begin
			if (btn_level_now)
				btn = ($urandom_range(0, 99) < 3) ? 1'b0 : 1'b1;
			else
				btn = ($urandom_range(0, 99) < 60) ? 1'b1 : 1'b0;
			case ($urandom_range(0, 3))
				0:       gas = 12'($urandom_range(0, 4095));
				1:       gas = pick_near(regs_model.disconnect_raw, 3);
				default: gas = pick_near(base_raw, 40);
			endcase
			foreach (oth[k])
				oth[k] = ($urandom_range(0, 1) != 0) ? 12'($urandom_range(0, 4095)) :
					pick_near(regs_model.disconnect_raw, 2);
			send_tick(btn, gas, oth[0], oth[1], oth[2]);
		end
		drain();
	endtask

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		sample_valid  = 1'b0;
		tick_in       = '0;
		reading_ready = 1'b0;
		mismatches       = 0;
		ticks_sent       = 0;
		readings_checked = 0;
		cycle_count      = 0;
		gap_pct          = 8;
		stall_pct        = 60;
		btn_level_now    = 1'b1;
		regs_model.warmup_ticks        = WARMUP_RST;
		regs_model.read_interval_ticks = INTERVAL_RST;
		regs_model.disconnect_raw      = DISCONNECT_RST;
		regs_model.ppm_gain            = GAIN_RST;
		seq_phase  = PH_WARMUP;
		tick_count = '0;
		btn_last   = 1'b1;
		base_raw   = '0;

		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_warmup_and_baseline();
		test_reading_values();
		test_register_extremes();
		test_random_traffic(8, 60, 250);
		test_random_traffic(60, 8, 250);
		test_random_traffic(0, 0, 250);

		repeat (8) @(negedge clk);
		if (pending_readings.size() != 0) begin
			$error("%0d expected readings never arrived", pending_readings.size());
			mismatches++;
		end
		$display("Sent %0d ticks through warm-up, directed corners and three idle patterns;",
			ticks_sent);
		$display("checked %0d readings, %0d field mismatches.", readings_checked, mismatches);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

### sim.f
rtl/gsas_pkg.sv
rtl/gsas_regs.sv
rtl/gsas_ctrl.sv
rtl/gsas_calc.sv
rtl/gas_sensor_acquisition_sequencer_unit.sv
tb/gas_sensor_acquisition_sequencer_unit_test.sv
